FILE: design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the range rate shaper
// Event codes, command codes and the item record passed from front to back.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int MaxRanges  = 8;
	localparam int QueueDepth = 8;
	localparam int ResultLimit = 64;
	localparam int RangeIdxW  = 3;
	localparam int RangeCntW  = 4;
	localparam int QueuePtrW  = 3;
	localparam int QueueCntW  = 4;
	localparam int LimitCntW  = 7;
	localparam int CmdDepthW  = 1;

	typedef enum logic [1:0] {
		MODE_PACKET = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_APPEND = 2'd2,
		MODE_FLUSH  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_ACCEPT  = 3'd0,
		EV_QUEUE   = 3'd1,
		EV_DROP    = 3'd2,
		EV_NORANGE = 3'd3,
		EV_RELEASE = 3'd4,
		EV_ADDED   = 3'd5,
		EV_REJECT  = 3'd6
	} event_t;

	// one input item after the front has latched it
	typedef struct packed {
		mode_t        mode;
		logic [31:0]  source_address;
		logic [15:0]  packet_length;
		logic [15:0]  packet_tag;
		logic [31:0]  range_first;
		logic [31:0]  range_last;
		logic [31:0]  byte_budget;
		logic [15:0]  period_ticks;
	} item_t;

	typedef struct packed {
		event_t                 kind;
		logic [15:0]            tag;
		logic [RangeIdxW-1:0]   idx;
		logic                   last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PACKET,
		ST_TICK_STEP,
		ST_TICK_REL,
		ST_EMIT
	} state_t;

endpackage

FILE: design/rrs_front.sv
// ----------------------------------------------------------------------------
// rrs_front: input side of the range rate shaper
// Latches items into a two-entry command queue so the input keeps moving
// while the back end works.
// ----------------------------------------------------------------------------
module rrs_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rrs_pkg::item_t in_item,
	output logic           cmd_valid,
	output rrs_pkg::item_t cmd_item,
	input  logic           cmd_take
);

	rrs_pkg::item_t             fifo_q [2];
	logic [rrs_pkg::CmdDepthW-1:0] wr_q, rd_q;
	logic [1:0]                  cnt_q;
	logic                        do_push, do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_item  = fifo_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

FILE: design/rrs_outq.sv
// ----------------------------------------------------------------------------
// rrs_outq: result queue
// Small fifo between the back end and the result port.
// ----------------------------------------------------------------------------
module rrs_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rrs_pkg::result_t  wr_data,
	output logic              almost_full,
	output logic              empty,
	input  logic              pop,
	output rrs_pkg::result_t  rd_data
);

	rrs_pkg::result_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic do_pop;

	assign empty       = (cnt_q == 3'd0);
	assign almost_full = (cnt_q >= 3'd3);
	assign rd_data     = mem_q[rd_q];
	assign do_pop      = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)     wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, do_pop};
		end
	end

endmodule

FILE: design/rrs_back.sv
// ----------------------------------------------------------------------------
// rrs_back: range table and shaping engine
// Binary search one probe per cycle, per-range counters and packet queues,
// tick walk over the ranges releasing queued packets, each once its head entry has been read.
// ----------------------------------------------------------------------------
module rrs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  rrs_pkg::item_t    cmd_item,
	output logic              cmd_take,
	input  logic              res_full,
	output logic              res_wr,
	output rrs_pkg::result_t  res_data
);

	localparam int RW = rrs_pkg::RangeIdxW;
	localparam int QW = rrs_pkg::QueuePtrW;

	logic [31:0] low_q    [rrs_pkg::MaxRanges];
	logic [31:0] high_q   [rrs_pkg::MaxRanges];
	logic [31:0] budget_q [rrs_pkg::MaxRanges];
	logic [15:0] period_q [rrs_pkg::MaxRanges];
	logic [31:0] bytes_q  [rrs_pkg::MaxRanges];
	logic [15:0] ticks_q  [rrs_pkg::MaxRanges];
	logic [QW-1:0] head_q [rrs_pkg::MaxRanges];
	logic [rrs_pkg::QueueCntW-1:0] qcnt_q [rrs_pkg::MaxRanges];
	logic [rrs_pkg::RangeCntW-1:0] count_q;

	// packet queues of all ranges in one memory, addressed {range, slot}
	logic [31:0] qmem_q [rrs_pkg::MaxRanges * rrs_pkg::QueueDepth];
	logic [31:0] qrd_q;

	rrs_pkg::state_t state_q, state_d;
	rrs_pkg::item_t  it_q;
	logic [rrs_pkg::RangeCntW-1:0] lo_q, hi_q;
	logic [RW-1:0] idx_q;
	logic [rrs_pkg::LimitCntW-1:0] nres_q;
	logic          found_q;
	rrs_pkg::result_t pend_q;
	logic [rrs_pkg::RangeCntW-1:0] walk_q;
	logic          relpend_q;
	logic          stale_q;

	logic [rrs_pkg::RangeCntW-1:0] mid;
	logic [RW-1:0] mid_i, walk_i;
	logic [32:0]   pk_sum, rel_sum;
	logic [15:0]   tick_next;
	logic [QW-1:0] tail;
	logic [QW+RW-1:0] wr_addr, rd_addr;
	logic          rel_ok;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_i  = mid[RW-1:0];
	assign walk_i = walk_q[RW-1:0];
	assign pk_sum = {1'b0, bytes_q[idx_q]} + {17'b0, it_q.packet_length};
	assign rel_sum = {1'b0, bytes_q[walk_i]} + {17'b0, qrd_q[15:0]};
	assign tick_next = ticks_q[walk_i] + 16'd1;
	assign tail    = head_q[idx_q] + qcnt_q[idx_q][QW-1:0];
	assign wr_addr = {idx_q, tail};
	assign rd_addr = {walk_i, head_q[walk_i]};
	assign cmd_take = (state_q == rrs_pkg::ST_IDLE) && cmd_valid;
	assign rel_ok  = qcnt_q[walk_i] != '0 &&
		nres_q < rrs_pkg::LimitCntW'(rrs_pkg::ResultLimit) &&
		rel_sum <= {1'b0, budget_q[walk_i]};

	always_ff @(posedge clk) begin
		qrd_q <= qmem_q[rd_addr];
		if (state_q == rrs_pkg::ST_PACKET && found_q && !res_full &&
				(qcnt_q[idx_q] != '0 || pk_sum > {1'b0, budget_q[idx_q]}) &&
				qcnt_q[idx_q] < rrs_pkg::QueueCntW'(rrs_pkg::QueueDepth)) begin
			qmem_q[wr_addr] <= {it_q.packet_tag, it_q.packet_length};
		end
	end

	always_comb begin
		state_d = state_q;
		res_wr  = 1'b0;
		res_data = pend_q;
		case (state_q)
			rrs_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd_item.mode)
						rrs_pkg::MODE_PACKET: state_d = rrs_pkg::ST_SEARCH;
						rrs_pkg::MODE_TICK:   state_d = rrs_pkg::ST_TICK_STEP;
						rrs_pkg::MODE_APPEND: state_d = rrs_pkg::ST_EMIT;
						default:              state_d = rrs_pkg::ST_IDLE;
					endcase
				end
			end
			rrs_pkg::ST_SEARCH: begin
				if (lo_q >= hi_q || found_q) state_d = rrs_pkg::ST_PACKET;
			end
			rrs_pkg::ST_PACKET: begin
				if (!res_full) state_d = rrs_pkg::ST_EMIT;
			end
			rrs_pkg::ST_EMIT: begin
				if (!res_full) begin
					res_wr  = 1'b1;
					state_d = rrs_pkg::ST_IDLE;
				end
			end
			rrs_pkg::ST_TICK_STEP: begin
				if (walk_q < count_q) begin
					if (tick_next == period_q[walk_i]) state_d = rrs_pkg::ST_TICK_REL;
				end else if (relpend_q) begin
					if (!res_full) begin
						res_wr = 1'b1;
						res_data.last = 1'b1;
						state_d = rrs_pkg::ST_IDLE;
					end
				end else begin
					state_d = rrs_pkg::ST_IDLE;
				end
			end
			rrs_pkg::ST_TICK_REL: begin
				// the held release goes out once the next one is known
				if (!res_full && !stale_q) begin
					if (rel_ok) begin
						if (relpend_q) res_wr = 1'b1;
					end else begin
						state_d = rrs_pkg::ST_TICK_STEP;
					end
				end
			end
			default: state_d = rrs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rrs_pkg::ST_IDLE;
			count_q   <= '0;
			found_q   <= 1'b0;
			relpend_q <= 1'b0;
			stale_q   <= 1'b0;
			walk_q    <= '0;
			nres_q    <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			idx_q     <= '0;
			it_q      <= '0;
			pend_q    <= '0;
			for (int i = 0; i < rrs_pkg::MaxRanges; i++) begin
				low_q[i]    <= '0;
				high_q[i]   <= '0;
				budget_q[i] <= '0;
				period_q[i] <= '0;
				bytes_q[i]  <= '0;
				ticks_q[i]  <= '0;
				head_q[i]   <= '0;
				qcnt_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				rrs_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						it_q      <= cmd_item;
						lo_q      <= '0;
						hi_q      <= count_q;
						found_q   <= 1'b0;
						walk_q    <= '0;
						nres_q    <= '0;
						relpend_q <= 1'b0;
						stale_q   <= 1'b0;
						case (cmd_item.mode)
							rrs_pkg::MODE_APPEND: begin
								if (count_q >= rrs_pkg::RangeCntW'(rrs_pkg::MaxRanges) ||
										cmd_item.range_first > cmd_item.range_last ||
										(count_q != '0 && cmd_item.range_first <=
										high_q[RW'(count_q - 1'b1)])) begin
									pend_q <= '{rrs_pkg::EV_REJECT, 16'd0, '0, 1'b1};
								end else begin
									low_q[RW'(count_q)]    <= cmd_item.range_first;
									high_q[RW'(count_q)]   <= cmd_item.range_last;
									budget_q[RW'(count_q)] <= cmd_item.byte_budget;
									period_q[RW'(count_q)] <= cmd_item.period_ticks;
									bytes_q[RW'(count_q)]  <= '0;
									ticks_q[RW'(count_q)]  <= '0;
									head_q[RW'(count_q)]   <= '0;
									qcnt_q[RW'(count_q)]   <= '0;
									count_q <= count_q + 1'b1;
									pend_q <= '{rrs_pkg::EV_ADDED, 16'd0, RW'(count_q), 1'b1};
								end
							end
							rrs_pkg::MODE_FLUSH: count_q <= '0;
							default: ;
						endcase
					end
				end
				rrs_pkg::ST_SEARCH: begin
					if (lo_q < hi_q && !found_q) begin
						if (it_q.source_address < low_q[mid_i]) hi_q <= mid;
						else if (it_q.source_address > high_q[mid_i]) lo_q <= mid + 1'b1;
						else begin
							found_q <= 1'b1;
							idx_q   <= mid_i;
						end
					end
				end
				rrs_pkg::ST_PACKET: begin
					if (!res_full) begin
						if (!found_q) begin
							pend_q <= '{rrs_pkg::EV_NORANGE, it_q.packet_tag, '0, 1'b1};
						end else if (qcnt_q[idx_q] != '0 ||
								pk_sum > {1'b0, budget_q[idx_q]}) begin
							if (qcnt_q[idx_q] <
									rrs_pkg::QueueCntW'(rrs_pkg::QueueDepth)) begin
								qcnt_q[idx_q] <= qcnt_q[idx_q] + 1'b1;
								pend_q <= '{rrs_pkg::EV_QUEUE, it_q.packet_tag, idx_q, 1'b1};
							end else begin
								pend_q <= '{rrs_pkg::EV_DROP, it_q.packet_tag, idx_q, 1'b1};
							end
						end else begin
							bytes_q[idx_q] <= pk_sum[31:0];
							pend_q <= '{rrs_pkg::EV_ACCEPT, it_q.packet_tag, idx_q, 1'b1};
						end
					end
				end
				rrs_pkg::ST_TICK_STEP: begin
					if (walk_q < count_q) begin
						if (tick_next == period_q[walk_i]) begin
							ticks_q[walk_i] <= '0;
							bytes_q[walk_i] <= '0;
						end else begin
							ticks_q[walk_i] <= tick_next;
							walk_q <= walk_q + 1'b1;
						end
					end
				end
				rrs_pkg::ST_TICK_REL: begin
					// qrd_q is valid for the current head unless a release just moved it
					if (!res_full) begin
						if (stale_q) begin
							stale_q <= 1'b0;
						end else if (rel_ok) begin
							head_q[walk_i]  <= head_q[walk_i] + 1'b1;
							qcnt_q[walk_i]  <= qcnt_q[walk_i] - 1'b1;
							bytes_q[walk_i] <= rel_sum[31:0];
							nres_q    <= nres_q + 1'b1;
							relpend_q <= 1'b1;
							stale_q   <= 1'b1;
							pend_q <= '{rrs_pkg::EV_RELEASE, qrd_q[31:16], walk_i, 1'b0};
						end else begin
							walk_q <= walk_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: design/range_rate_shaper_top.sv
// ----------------------------------------------------------------------------
// range_rate_shaper_top: per-range byte-rate shaper
// Top level: command queue, shaping engine and result queue.
// ----------------------------------------------------------------------------
// A packet is taken, then a binary search probes the range table (up to
// four probes for eight ranges) and a final search step sees the outcome;
// an update and a write into the result queue follow. An append is taken
// and then its result written; a flush is done when it is taken. A tick
// is taken, steps through each range in turn and ends with a final step; a
// range whose period ends also enters a release state, where each released
// packet waits for the head entry of the range's packet queue, since that
// comes from a memory with a registered read port. Each release of a tick
// is held until the next is known so that last is marked on the final one.
// Input items wait in a two-entry queue; results in a four-entry queue.
module range_rate_shaper_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [31:0] source_address,
	input  logic [15:0] packet_length,
	input  logic [15:0] packet_tag,
	input  logic [31:0] range_first,
	input  logic [31:0] range_last,
	input  logic [31:0] byte_budget,
	input  logic [15:0] period_ticks,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [15:0] out_tag,
	output logic [2:0]  range_index,
	output logic        last
);

	rrs_pkg::item_t   in_item, cmd_item;
	rrs_pkg::result_t res_data, out_data;
	logic cmd_valid, cmd_take, res_wr, res_full;

	assign in_item = '{rrs_pkg::mode_t'(mode), source_address, packet_length,
		packet_tag, range_first, range_last, byte_budget, period_ticks};

	rrs_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.cmd_valid, .cmd_item, .cmd_take
	);

	rrs_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_item, .cmd_take,
		.res_full, .res_wr, .res_data
	);

	rrs_outq u_outq (
		.clk, .arst_n, .wr(res_wr), .wr_data(res_data),
		.almost_full(res_full), .empty, .pop, .rd_data(out_data)
	);

	assign event_kind  = out_data.kind;
	assign out_tag     = out_data.tag;
	assign range_index = out_data.idx;
	assign last        = out_data.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> !res_full)
		else $error("result queue overflow");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("command taken while none waits");

	a_write_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |=> !empty)
		else $error("result written but queue empty");

endmodule
